@@ hdl/forecast_error_metrics_core_defines.svh @@
// assertion helpers shared by the rtl
`ifndef FORECAST_ERROR_METRICS_CORE_DEFINES_SVH
`define FORECAST_ERROR_METRICS_CORE_DEFINES_SVH

// same-cycle implication
`define FEM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/fem_pkg.sv @@
`timescale 1ns / 1ps
package fem_pkg;

  localparam int unsigned DivNumW = 64;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned SqrtInW = 64;
  localparam int unsigned SqrtOutW = 32;

  // request to the shared divider
  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  // request to the square root unit
  typedef struct packed {
    logic               start;
    logic [SqrtInW-1:0] radicand;
  } sqrt_req_t;

endpackage

@@ hdl/fem_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module fem_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fem_pkg::div_req_t               req_i,
  output logic                            done_o,
  output logic [fem_pkg::DivNumW-1:0]     quotient_o
);

  localparam int unsigned CntW = $clog2(fem_pkg::DivNumW + 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [fem_pkg::DivDenW-1:0]   rem_q, rem_d;
  logic [fem_pkg::DivNumW-1:0]   quo_q, quo_d;
  logic [fem_pkg::DivDenW-1:0]   den_q, den_d;
  logic [fem_pkg::DivDenW:0]     trial;
  logic [fem_pkg::DivDenW:0]     diff;
  logic                          ge;

  // one compare and subtract step
  always_comb begin
    trial = {rem_q, quo_q[fem_pkg::DivNumW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  // sequencing of the iterations
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(fem_pkg::DivNumW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[fem_pkg::DivDenW-1:0] : trial[fem_pkg::DivDenW-1:0];
      quo_d = {quo_q[fem_pkg::DivNumW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/fem_sqrt.sv @@
`timescale 1ns / 1ps
// digit-by-digit integer square root, two radicand bits per cycle
module fem_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fem_pkg::sqrt_req_t               req_i,
  output logic                             done_o,
  output logic [fem_pkg::SqrtOutW-1:0]     root_o
);

  localparam int unsigned CntW = $clog2(fem_pkg::SqrtOutW + 1);
  localparam int unsigned RemW = fem_pkg::SqrtOutW + 3;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [fem_pkg::SqrtInW-1:0]     x_q, x_d;
  logic [RemW-1:0]                 rem_q, rem_d;
  logic [fem_pkg::SqrtOutW-1:0]    root_q, root_d;
  logic [RemW-1:0]                 shifted;
  logic [RemW-1:0]                 trial;
  logic                            ge;

  // trial subtract of the next root bit
  always_comb begin
    shifted = {rem_q[RemW-3:0], x_q[fem_pkg::SqrtInW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = (shifted >= trial);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(fem_pkg::SqrtOutW);
      x_d    = req_i.radicand;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      x_d    = {x_q[fem_pkg::SqrtInW-3:0], 2'b00};
      rem_d  = ge ? (shifted - trial) : shifted;
      root_d = {root_q[fem_pkg::SqrtOutW-2:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/forecast_error_metrics_core.sv @@
// a pair is accepted in S_IDLE, accumulated in S_ACC and S_SQ, and one with nonzero actual
// waits in S_RDIV for one 64-step division. A final pair then runs the mean-square division,
// the 32-step root (skipped if the mean square saturates), the mean-absolute division and, if
// any actual was nonzero, the percent division. One pair at a time; one shared divider.
// reset: rst_ni low clears the sequencer, all accumulators and the output valid
`timescale 1ns / 1ps
`include "forecast_error_metrics_core_defines.svh"
module forecast_error_metrics_core #(
  parameter int unsigned MAX_SERIES = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] actual_value, [63:32] predicted_value
  input  logic [63:0]   s_axis_tdata,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] root_mean_square, [63:32] mean_absolute, [95:64] mean_percent,
  // [112:96] samples_seen, [119:113] zero
  output logic [119:0]  m_axis_tdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_RDIV = 4'd3;
  localparam logic [3:0] S_MSE  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_MAE  = 4'd6;
  localparam logic [3:0] S_MAPE = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  localparam logic [16:0] MaxCnt = 17'(MAX_SERIES);

  logic [3:0]  state_q, state_d;
  logic        last_q, last_d;
  logic        nzact_q, nzact_d;
  logic [31:0] ae_q, ae_d;
  logic [31:0] aa_q, aa_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] sq_sum_q, sq_sum_d;
  logic [47:0] abs_sum_q, abs_sum_d;
  logic [47:0] ratio_sum_q, ratio_sum_d;
  logic [16:0] pair_cnt_q, pair_cnt_d;
  logic [16:0] nz_cnt_q, nz_cnt_d;
  logic [31:0] rmse_q, rmse_d;
  logic [31:0] mae_q, mae_d;
  logic [31:0] mape_q, mape_d;
  logic        out_valid_q, out_valid_d;
  logic [119:0] out_data_q, out_data_d;

  fem_pkg::div_req_t  div_req_q, div_req_d;
  fem_pkg::sqrt_req_t sqrt_req_q, sqrt_req_d;
  logic               div_done;
  logic [63:0]        div_quo;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;

  logic signed [32:0] err;
  logic signed [32:0] act;
  logic [32:0]        err_abs;
  logic [32:0]        act_abs;
  logic [64:0]        sq_add;
  logic [48:0]        abs_add;
  logic [48:0]        ratio_add;
  logic [31:0]        ratio_sat;
  logic [54:0]        ratio_x100;
  logic               emit_fire;

  fem_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  fem_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req_q),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  // error and magnitudes of the incoming pair
  always_comb begin
    act     = {s_axis_tdata[31], s_axis_tdata[31:0]};
    err     = act - {s_axis_tdata[63], s_axis_tdata[63:32]};
    err_abs = err[32] ? 33'(-err) : 33'(err);
    act_abs = act[32] ? 33'(-act) : 33'(act);
  end

  // saturating accumulator adds
  always_comb begin
    sq_add     = {1'b0, sq_sum_q} + {17'd0, prod_q[63:16]};
    abs_add    = {1'b0, abs_sum_q} + {17'd0, ae_q};
    ratio_sat  = (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
    ratio_add  = {1'b0, ratio_sum_q} + {17'd0, ratio_sat};
    ratio_x100 = ({7'd0, ratio_sum_q} << 6) + ({7'd0, ratio_sum_q} << 5)
               + ({7'd0, ratio_sum_q} << 2);
  end

  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    nzact_d     = nzact_q;
    ae_d        = ae_q;
    aa_d        = aa_q;
    prod_d      = prod_q;
    sq_sum_d    = sq_sum_q;
    abs_sum_d   = abs_sum_q;
    ratio_sum_d = ratio_sum_q;
    pair_cnt_d  = pair_cnt_q;
    nz_cnt_d    = nz_cnt_q;
    rmse_d      = rmse_q;
    mae_d       = mae_q;
    mape_d      = mape_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    div_req_d   = '0;
    sqrt_req_d  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          last_d  = s_axis_tlast;
          nzact_d = (s_axis_tdata[31:0] != '0);
          ae_d    = err_abs[31:0];
          aa_d    = act_abs[31:0];
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (pair_cnt_q < MaxCnt) begin
          prod_d     = ae_q * ae_q;
          abs_sum_d  = abs_add[48] ? '1 : abs_add[47:0];
          pair_cnt_d = pair_cnt_q + 17'd1;
          state_d    = S_SQ;
        end else if (last_q) begin
          div_req_d = '{start: 1'b1, dividend: sq_sum_q, divisor: {15'd0, pair_cnt_q}};
          state_d   = S_MSE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SQ: begin
        sq_sum_d = sq_add[64] ? '1 : sq_add[63:0];
        if (nzact_q) begin
          div_req_d = '{start: 1'b1, dividend: {16'd0, ae_q, 16'd0}, divisor: aa_q};
          state_d   = S_RDIV;
        end else if (last_q) begin
          div_req_d = '{start: 1'b1,
                        dividend: (sq_add[64] ? '1 : sq_add[63:0]),
                        divisor: {15'd0, pair_cnt_q}};
          state_d   = S_MSE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          ratio_sum_d = ratio_add[48] ? '1 : ratio_add[47:0];
          nz_cnt_d    = nz_cnt_q + 17'd1;
          if (last_q) begin
            div_req_d = '{start: 1'b1, dividend: sq_sum_q, divisor: {15'd0, pair_cnt_q}};
            state_d   = S_MSE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_MSE: begin
        if (div_done) begin
          if (div_quo[63:48] != '0) begin
            rmse_d    = '1;
            div_req_d = '{start: 1'b1, dividend: {16'd0, abs_sum_q},
                          divisor: {15'd0, pair_cnt_q}};
            state_d   = S_MAE;
          end else begin
            sqrt_req_d = '{start: 1'b1, radicand: {div_quo[47:0], 16'd0}};
            state_d    = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          rmse_d    = sqrt_root;
          div_req_d = '{start: 1'b1, dividend: {16'd0, abs_sum_q},
                        divisor: {15'd0, pair_cnt_q}};
          state_d   = S_MAE;
        end
      end
      S_MAE: begin
        if (div_done) begin
          mae_d = (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
          if (nz_cnt_q != '0) begin
            div_req_d = '{start: 1'b1, dividend: {9'd0, ratio_x100},
                          divisor: {15'd0, nz_cnt_q}};
            state_d   = S_MAPE;
          end else begin
            mape_d  = '0;
            state_d = S_EMIT;
          end
        end
      end
      S_MAPE: begin
        if (div_done) begin
          mape_d  = (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // result register frees up, load and clear the series
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, pair_cnt_q, mape_q, mae_q, rmse_q};
          sq_sum_d    = '0;
          abs_sum_d   = '0;
          ratio_sum_d = '0;
          pair_cnt_d  = '0;
          nz_cnt_d    = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sq_sum_q    <= '0;
      abs_sum_q   <= '0;
      ratio_sum_q <= '0;
      pair_cnt_q  <= '0;
      nz_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      div_req_q   <= '0;
      sqrt_req_q  <= '0;
    end else begin
      state_q     <= state_d;
      sq_sum_q    <= sq_sum_d;
      abs_sum_q   <= abs_sum_d;
      ratio_sum_q <= ratio_sum_d;
      pair_cnt_q  <= pair_cnt_d;
      nz_cnt_q    <= nz_cnt_d;
      out_valid_q <= out_valid_d;
      div_req_q   <= div_req_d;
      sqrt_req_q  <= sqrt_req_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    nzact_q    <= nzact_d;
    ae_q       <= ae_d;
    aa_q       <= aa_d;
    prod_q     <= prod_d;
    rmse_q     <= rmse_d;
    mae_q      <= mae_d;
    mape_q     <= mape_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `FEM_ASSERT_NOW(a_div_done_waiting, clk_i, rst_ni, div_done, (state_q == S_RDIV || state_q == S_MSE || state_q == S_MAE || state_q == S_MAPE), "divider finished outside a wait state")
  `FEM_ASSERT_NOW(a_sqrt_done_waiting, clk_i, rst_ni, sqrt_done, (state_q == S_SQRT), "root finished outside its wait state")
  `FEM_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, emit_fire, (pair_cnt_q == '0 && m_axis_tvalid), "series not cleared after result")
  `FEM_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, (nz_cnt_q <= pair_cnt_q), "nonzero count above pair count")

endmodule
